// ----- sv/ptrm_pkg.sv -----
package ptrm_pkg;

    localparam int MAX_TASKS = 16;
    localparam int SLOT_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam int QUEUE_DEPTH = 2;

    localparam logic [1:0] OP_TICK = 2'd0;
    localparam logic [1:0] OP_SET  = 2'd1;
    localparam logic [1:0] OP_WAIT = 2'd2;
    localparam logic [1:0] OP_STAT = 2'd3;

    localparam logic [2:0] EV_MISS    = 3'd0;
    localparam logic [2:0] EV_RELEASE = 3'd1;
    localparam logic [2:0] EV_SUSPEND = 3'd2;
    localparam logic [2:0] EV_RESUME  = 3'd3;
    localparam logic [2:0] EV_STATS   = 3'd4;

    typedef struct packed {
        logic [1:0]  opcode;
        logic [3:0]  task_index;
        logic [15:0] period_ticks;
        logic [15:0] deadline_ticks;
        logic [15:0] phase_ticks;
        logic        has_successor;
        logic [3:0]  successor_index;
    } cmd_t;

    typedef struct packed {
        logic [2:0]  event_kind;
        logic [3:0]  event_task;
        logic [31:0] activation_total;
        logic [15:0] miss_total;
        logic        last_event;
    } result_t;

    typedef enum logic [2:0] {
        JOB_TICK,
        JOB_SET,
        JOB_WAIT,
        JOB_STAT,
        JOB_NOP
    } job_kind_t;

    typedef struct packed {
        job_kind_t         kind;
        logic [SLOT_W-1:0] slot;
        logic [15:0]       period;
        logic [15:0]       deadline;
        logic [15:0]       phase;
        logic              succ_valid;
        logic [3:0]        succ_index;
        logic [CNT_W-1:0]  walk_count;
    } job_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_LOAD,
        ST_DUE,
        ST_DIV,
        ST_REL,
        ST_NEXT,
        ST_SELF,
        ST_SUCC,
        ST_STAT,
        ST_FIN
    } back_state_t;

endpackage

// ----- sv/ptrm_front.sv -----
module ptrm_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  ptrm_pkg::cmd_t cmd,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [4:0]    cfg_data,
    output logic          head_valid,
    output ptrm_pkg::job_t head,
    input  logic          pop
);
    import ptrm_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [4:0]        active_reg;
    job_t              queue_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [QCNT_W-1:0] fill_reg;
    job_t              job;
    logic              push;

    assign cfg_ready = 1'b1;
    assign busy = (fill_reg == QCNT_W'(QUEUE_DEPTH));
    assign push = start && !busy;
    assign head_valid = (fill_reg != '0);
    assign head = queue_reg[rd_ptr_reg];

    always_comb
    begin
        job.slot = SLOT_W'(cmd.task_index);
        job.period = cmd.period_ticks;
        job.deadline = cmd.deadline_ticks;
        job.phase = cmd.phase_ticks;
        job.succ_valid = cmd.has_successor;
        job.succ_index = cmd.successor_index;
        if (int'(active_reg) > MAX_TASKS)
        begin
            job.walk_count = CNT_W'(MAX_TASKS);
        end
        else
        begin
            job.walk_count = CNT_W'(active_reg);
        end
        unique case (cmd.opcode)
            OP_TICK: job.kind = JOB_TICK;
            OP_SET:  job.kind = JOB_SET;
            OP_WAIT: job.kind = JOB_WAIT;
            default: job.kind = JOB_STAT;
        endcase
        if (cmd.opcode != OP_TICK && int'(cmd.task_index) >= MAX_TASKS)
        begin
            job.kind = JOB_NOP;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                active_reg <= cfg_data;
            end
            if (push)
            begin
                wr_ptr_reg <= (int'(wr_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop && head_valid)
            begin
                rd_ptr_reg <= (int'(rd_ptr_reg) == QUEUE_DEPTH - 1) ? '0 : rd_ptr_reg + 1'b1;
            end
            fill_reg <= fill_reg + QCNT_W'(push) - QCNT_W'(pop && head_valid);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            queue_reg[wr_ptr_reg] <= job;
        end
    end

endmodule

// ----- sv/ptrm_back.sv -----
module ptrm_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            head_valid,
    input  ptrm_pkg::job_t  head,
    output logic            pop,
    output logic            result_valid,
    output ptrm_pkg::result_t result
);
    import ptrm_pkg::*;

    localparam int DIV_CYCLES = 16;
    localparam int DCNT_W = $clog2(DIV_CYCLES);

    back_state_t       state_reg, state_next;
    logic [SLOT_W-1:0] slot_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [31:0]       tick_reg;
    logic [CNT_W-1:0]  walk_reg;
    logic [SLOT_W-1:0] succ_reg;

    logic [15:0] period_reg [MAX_TASKS];
    logic [15:0] deadline_reg [MAX_TASKS];
    logic [15:0] phase_reg [MAX_TASKS];
    logic [4:0]  successor_reg [MAX_TASKS];
    logic        running_reg [MAX_TASKS];
    logic [31:0] act_reg [MAX_TASKS];
    logic [15:0] miss_reg [MAX_TASKS];

    logic [15:0] w_per_reg, w_dl_reg, w_ph_reg;
    logic        w_run_reg;
    logic [31:0] w_act_reg;
    logic [15:0] w_mis_reg;
    logic [47:0] prod_reg;

    logic [16:0]       rem_reg;
    logic [31:0]       dvd_reg;
    logic [DCNT_W-1:0] dcnt_reg;

    result_t pend_reg;
    logic    pend_valid_reg;
    result_t result_reg, result_next;
    logic    result_valid_reg, result_valid_next;

    logic [SLOT_W-1:0] rd_addr;
    logic [SLOT_W-1:0] walk_slot;
    logic              skip;
    logic              miss;
    logic              run_after;
    logic [15:0]       mis_after;
    logic [48:0]       due;
    logic [31:0]       act_inc;
    logic [16:0]       rem_a, rem_b;
    logic              succ_ok;
    logic              emit_en;
    result_t           emit_word;
    logic              flush;

    assign walk_slot = walk_reg[SLOT_W-1:0];
    assign result_valid = result_valid_reg;
    assign result = result_reg;
    assign pop = (state_reg == ST_IDLE) && head_valid;

    always_comb
    begin
        unique case (state_reg)
            ST_SUCC: rd_addr = succ_reg;
            ST_LOAD: rd_addr = walk_slot;
            default: rd_addr = slot_reg;
        endcase
    end

    assign skip = (tick_reg < {16'd0, w_ph_reg});
    assign due = {33'd0, w_ph_reg} + {33'd0, w_dl_reg} + {1'b0, prod_reg};
    assign miss = (w_per_reg != '0) && (w_dl_reg != '0) && w_run_reg && (due < {17'd0, tick_reg});
    assign run_after = w_run_reg && !miss;
    assign mis_after = (miss && w_mis_reg != 16'hFFFF) ? w_mis_reg + 16'd1 : w_mis_reg;
    assign act_inc = (w_act_reg != 32'hFFFFFFFF) ? w_act_reg + 32'd1 : w_act_reg;
    assign succ_ok = successor_reg[rd_addr][4] && (int'(successor_reg[rd_addr][3:0]) < MAX_TASKS);

    always_comb
    begin
        logic [16:0] t;
        t = {rem_reg[15:0], dvd_reg[31]};
        rem_a = (t >= {1'b0, w_per_reg}) ? t - {1'b0, w_per_reg} : t;
        t = {rem_a[15:0], dvd_reg[30]};
        rem_b = (t >= {1'b0, w_per_reg}) ? t - {1'b0, w_per_reg} : t;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (head_valid)
                begin
                    unique case (head.kind)
                        JOB_TICK: state_next = (head.walk_count == '0) ? ST_IDLE : ST_LOAD;
                        JOB_WAIT: state_next = ST_SELF;
                        JOB_STAT: state_next = ST_STAT;
                        default:  state_next = ST_IDLE;
                    endcase
                end
            end
            ST_LOAD: state_next = ST_DUE;
            ST_DUE:
            begin
                if (skip || w_per_reg == '0 || run_after)
                begin
                    state_next = ST_NEXT;
                end
                else
                begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:  state_next = (dcnt_reg == DCNT_W'(DIV_CYCLES - 1)) ? ST_REL : ST_DIV;
            ST_REL:  state_next = ST_NEXT;
            ST_NEXT: state_next = (walk_reg + 1'b1 == count_reg) ? ST_FIN : ST_LOAD;
            ST_SELF: state_next = succ_ok ? ST_SUCC : ST_FIN;
            ST_SUCC: state_next = ST_FIN;
            ST_STAT: state_next = ST_FIN;
            ST_FIN:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        emit_en = 1'b0;
        flush = 1'b0;
        emit_word.event_kind = EV_STATS;
        emit_word.event_task = 4'(rd_addr);
        emit_word.activation_total = act_reg[rd_addr];
        emit_word.miss_total = miss_reg[rd_addr];
        emit_word.last_event = 1'b0;
        unique case (state_reg)
            ST_DUE:
            begin
                emit_en = !skip && miss;
                emit_word.event_kind = EV_MISS;
                emit_word.event_task = 4'(walk_slot);
                emit_word.activation_total = w_act_reg;
                emit_word.miss_total = mis_after;
            end
            ST_REL:
            begin
                emit_en = (rem_reg == '0);
                emit_word.event_kind = EV_RELEASE;
                emit_word.event_task = 4'(walk_slot);
                emit_word.activation_total = act_inc;
                emit_word.miss_total = w_mis_reg;
            end
            ST_SELF:
            begin
                emit_en = 1'b1;
                emit_word.event_kind = EV_SUSPEND;
            end
            ST_SUCC:
            begin
                emit_en = 1'b1;
                emit_word.event_kind = EV_RESUME;
            end
            ST_STAT:
            begin
                emit_en = 1'b1;
            end
            ST_FIN:
            begin
                flush = 1'b1;
            end
            default:
            begin
                emit_en = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        result_valid_next = 1'b0;
        result_next = pend_reg;
        if (pend_valid_reg && (emit_en || flush))
        begin
            result_valid_next = 1'b1;
            result_next.last_event = flush;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            tick_reg <= '0;
            pend_valid_reg <= 1'b0;
            result_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_TASKS; i++)
            begin
                period_reg[i] <= '0;
                deadline_reg[i] <= '0;
                phase_reg[i] <= '0;
                successor_reg[i] <= '0;
                running_reg[i] <= 1'b1;
                act_reg[i] <= '0;
                miss_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            result_valid_reg <= result_valid_next;
            if (emit_en)
            begin
                pend_valid_reg <= 1'b1;
            end
            else if (flush)
            begin
                pend_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE:
                begin
                    if (head_valid && head.kind == JOB_TICK && tick_reg != 32'hFFFFFFFF)
                    begin
                        tick_reg <= tick_reg + 32'd1;
                    end
                    if (head_valid && head.kind == JOB_SET)
                    begin
                        period_reg[head.slot] <= head.period;
                        deadline_reg[head.slot] <= head.deadline;
                        phase_reg[head.slot] <= head.phase;
                        successor_reg[head.slot] <= {head.succ_valid, head.succ_index};
                    end
                end
                ST_DUE:
                begin
                    if (!skip && miss)
                    begin
                        running_reg[walk_slot] <= 1'b0;
                        miss_reg[walk_slot] <= mis_after;
                    end
                end
                ST_REL:
                begin
                    if (rem_reg == '0)
                    begin
                        running_reg[walk_slot] <= 1'b1;
                        act_reg[walk_slot] <= act_inc;
                    end
                end
                ST_SELF:
                begin
                    running_reg[rd_addr] <= 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit_en)
        begin
            pend_reg <= emit_word;
        end
        result_reg <= result_next;
        unique case (state_reg)
            ST_IDLE:
            begin
                slot_reg <= head.slot;
                count_reg <= head.walk_count;
                walk_reg <= '0;
            end
            ST_LOAD:
            begin
                w_per_reg <= period_reg[rd_addr];
                w_dl_reg <= deadline_reg[rd_addr];
                w_ph_reg <= phase_reg[rd_addr];
                w_run_reg <= running_reg[rd_addr];
                w_act_reg <= act_reg[rd_addr];
                w_mis_reg <= miss_reg[rd_addr];
                prod_reg <= period_reg[rd_addr] * act_reg[rd_addr];
            end
            ST_DUE:
            begin
                w_mis_reg <= mis_after;
                rem_reg <= '0;
                dvd_reg <= tick_reg - {16'd0, w_ph_reg};
                dcnt_reg <= '0;
            end
            ST_DIV:
            begin
                rem_reg <= rem_b;
                dvd_reg <= {dvd_reg[29:0], 2'b00};
                dcnt_reg <= dcnt_reg + 1'b1;
            end
            ST_NEXT:
            begin
                walk_reg <= walk_reg + 1'b1;
            end
            ST_SELF:
            begin
                succ_reg <= SLOT_W'(successor_reg[rd_addr][3:0]);
            end
            default:
            begin
            end
        endcase
    end

endmodule

// ----- sv/periodic_task_release_monitor_top.sv -----
// Periodic task release and deadline monitor.
// Commands enter on cmd and are taken at a rising edge where start is high
// and busy is low. A two-word queue sits between the command front end and
// the execution engine, so busy rises only when two commands are waiting.
// The active task count is written over cfg_valid/cfg_ready/cfg_data, which
// is always ready; it should be written only while no command is pending.
// Each result word appears on result for one cycle with result_valid high;
// the receiver cannot stall, and last_event marks the final word of a
// command. A word is held in a pending register until the engine produces
// the next word of the same command or finishes the command, and then it
// leaves through the result register. A set command writes the task table
// as it is taken from the queue; a stats command gives one word, and a wait
// gives a suspend word and, if the task has a valid successor, a resume word.
// A tick walks the slots: a load with the period-times-activations multiply,
// a compare for the deadline, then, only for a stopped slot, a remainder unit
// that retires two quotient bits per cycle for the release check, and a step
// to the next slot. The walk lies between the idle and the finish states.
// Reset clears the tick counter, the task table and the count register and
// marks every task as running; the block is usable at once.
module periodic_task_release_monitor_top (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  ptrm_pkg::cmd_t    cmd,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [4:0]        cfg_data,
    output logic              result_valid,
    output ptrm_pkg::result_t result
);
    import ptrm_pkg::*;

    logic head_valid;
    job_t head;
    logic pop;

    ptrm_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .head_valid (head_valid),
        .head       (head),
        .pop        (pop)
    );

    ptrm_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .result_valid (result_valid),
        .result       (result)
    );

endmodule
